// ===== rtl/mpb_pkg.sv =====
package mpb_pkg;

  localparam int CH_BITS   = 16;
  localparam int MASK_BITS = 8;

  typedef logic [CH_BITS-1:0]   chan_t;
  typedef logic [MASK_BITS-1:0] mask_t;
  typedef logic [1:0]           path_t;
  typedef chan_t [2:0]          rgb_t;

  localparam chan_t CH_ONE    = '1;
  localparam mask_t MASK_FULL = '1;

  localparam path_t PATH_BACK   = 2'd0;
  localparam path_t PATH_FX     = 2'd1;
  localparam path_t PATH_PREMUL = 2'd2;
  localparam path_t PATH_LERP   = 2'd3;

  typedef struct packed {
    chan_t back_red;
    chan_t back_green;
    chan_t back_blue;
    chan_t back_alpha;
    chan_t fx_red;
    chan_t fx_green;
    chan_t fx_blue;
    chan_t fx_alpha;
    mask_t mask_level;
    chan_t clip_coverage;
  } pixel_in_t;

  typedef struct packed {
    chan_t res_red;
    chan_t res_green;
    chan_t res_blue;
    chan_t res_alpha;
    path_t blend_path;
  } pixel_out_t;

endpackage

// ===== rtl/mpb_divider.sv =====
// Pipelined restoring divider: one quotient bit per stage, MSB first.
// All lanes share one divisor. The quotient must fit in Q_BITS bits, that is
// the dividend must be below the divisor shifted up by Q_BITS.
module mpb_divider #(
  parameter int LANES  = 1,
  parameter int NUM_W  = 32,
  parameter int DEN_W  = 16,
  parameter int Q_BITS = 16,
  parameter int SIDE_W = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [LANES-1:0][NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]             in_den,
  input  logic [SIDE_W-1:0]            in_side,
  output logic                         out_valid,
  output logic [LANES-1:0][Q_BITS-1:0] out_quot,
  output logic [SIDE_W-1:0]            out_side
);

  localparam int CW = (NUM_W > DEN_W + Q_BITS) ? NUM_W : DEN_W + Q_BITS;

  logic                         vld  [Q_BITS+1];
  logic [LANES-1:0][Q_BITS-1:0] quo  [Q_BITS+1];
  logic [SIDE_W-1:0]            side [Q_BITS+1];
  logic [LANES-1:0][NUM_W-1:0]  rem  [Q_BITS];
  logic [DEN_W-1:0]             den  [Q_BITS];

  assign vld[0]  = in_valid;
  assign quo[0]  = '0;
  assign side[0] = in_side;
  assign rem[0]  = in_num;
  assign den[0]  = in_den;

  for (genvar s = 0; s < Q_BITS; s++) begin : g_stage
    localparam int BIT = Q_BITS - 1 - s;

    logic [CW-1:0]                step;
    logic [LANES-1:0][NUM_W-1:0]  rem_next;
    logic [LANES-1:0][Q_BITS-1:0] quo_next;

    assign step = CW'(den[s]) << BIT;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        if (CW'(rem[s][l]) >= step) begin
          rem_next[l] = NUM_W'(CW'(rem[s][l]) - step);
          quo_next[l] = (quo[s][l] << 1) | Q_BITS'(1);
        end else begin
          rem_next[l] = rem[s][l];
          quo_next[l] = quo[s][l] << 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      quo[s+1]  <= quo_next;
      side[s+1] <= side[s];
    end

    // The last stage only needs the quotient bit, not the remainder.
    if (BIT > 0) begin : g_carry
      always_ff @(posedge clk) begin
        rem[s+1] <= rem_next;
        den[s+1] <= den[s];
      end
    end
  end

  assign out_valid = vld[Q_BITS];
  assign out_quot  = quo[Q_BITS];
  assign out_side  = side[Q_BITS];

endmodule

// ===== rtl/masked_premultiplied_blend.sv =====
// Channel | Signals                      | Direction | Handshake
// --------+------------------------------+-----------+---------------------------
// pixel   | start, busy, pixel           | in        | beat when start && !busy
// result  | done, result                 | out       | beat when done, one cycle
// config  | cfg_valid, cfg_ready, cfg_data | in      | beat when cfg_valid && cfg_ready
//
// One pixel is taken every clock; busy stays low and cfg_ready stays high.
// Most of the latency is the divider for the un-premultiply of the colors,
// which resolves one quotient bit per stage; the blend amount takes three
// stages of reciprocal estimate and correction.
// rst is synchronous and clears the valid bits and sets the opacity to full.
// The receiver cannot stall: every result is shown for exactly one cycle.
module masked_premultiplied_blend (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  mpb_pkg::pixel_in_t  pixel,
  output logic                done,
  output mpb_pkg::pixel_out_t result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  mpb_pkg::chan_t      cfg_data
);
  import mpb_pkg::*;

  localparam int CB      = CH_BITS;
  localparam int OW      = CB + MASK_BITS;
  localparam int PW      = 2*CB + MASK_BITS;
  localparam int YW      = PW + 1;
  localparam int DW      = CB + MASK_BITS;
  localparam int MW      = 2*CB;
  localparam int XW      = 2*CB + 1;
  localparam int HW      = YW - CB;
  localparam int RW      = CB + 3;
  localparam int RS      = CB + 10;
  localparam int LATENCY = CB + 13;

  localparam logic [DW-1:0] A_DEN      = DW'(MASK_FULL) * DW'(CH_ONE);
  localparam logic [PW-1:0] FULL_SCALE = PW'(A_DEN) * PW'(CH_ONE);
  localparam logic [YW-1:0] A_HALF     = YW'(A_DEN >> 1);
  localparam logic [XW-1:0] ONE_HALF   = XW'(CH_ONE >> 1);
  localparam logic [63:0]   RECIP_WIDE = (64'd1 << (2*CB + 10)) / 64'(A_DEN);
  localparam logic [RW-1:0] RECIP      = RW'(RECIP_WIDE);

  typedef logic [2:0][MW-1:0] rgb_prod_t;
  typedef logic [2:0][XW-1:0] rgb_sum_t;

  typedef struct packed {
    pixel_in_t px;
    rgb_t      pmo;
    rgb_t      pmb;
    logic      zero;
    logic      full;
  } amount_side_t;

  typedef struct packed {
    pixel_out_t prov;
    logic [2:0] sat;
  } color_side_t;

  // x / ONE for x up to ONE*ONE + ONE/2, with ONE = 2^CB - 1.
  function automatic chan_t div_one(input logic [XW-1:0] x);
    logic [XW:0] t;
    t = (XW+1)'(x) + (XW+1)'(x >> CB) + (XW+1)'(1);
    return chan_t'(t >> CB);
  endfunction

  // Configuration and fixed handshake levels.
  chan_t opacity;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      opacity <= CH_ONE;
    end else if (cfg_valid && cfg_ready) begin
      opacity <= cfg_data;
    end
  end

  // Stage 1: opacity times mask.
  logic            v1;
  pixel_in_t       px1;
  logic [OW-1:0]   om1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    px1 <= pixel;
    om1 <= OW'(opacity) * OW'(pixel.mask_level);
  end

  // Stage 2: full product with the coverage.
  logic            v2;
  pixel_in_t       px2;
  logic [PW-1:0]   prod2;
  rgb_t            back2;
  rgb_t            fx2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    px2   <= px1;
    prod2 <= PW'(om1) * PW'(px1.clip_coverage);
  end

  assign back2 = {px2.back_blue, px2.back_green, px2.back_red};
  assign fx2   = {px2.fx_blue, px2.fx_green, px2.fx_red};

  // Stage 3: path flags, rounded dividend, premultiply products.
  logic            v3;
  pixel_in_t       px3;
  logic            zero3;
  logic            full3;
  logic [YW-1:0]   y3;
  rgb_prod_t       cpo3;
  rgb_prod_t       cpb3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    px3   <= px2;
    zero3 <= (prod2 == '0);
    full3 <= (prod2 >= FULL_SCALE);
    y3    <= YW'(prod2) + A_HALF;
    for (int i = 0; i < 3; i++) begin
      cpo3[i] <= MW'(back2[i]) * MW'(px2.back_alpha);
      cpb3[i] <= MW'(fx2[i]) * MW'(px2.fx_alpha);
    end
  end

  // Stage 4: premultiplied channels.
  logic            v4;
  amount_side_t    aside4;
  logic [YW-1:0]   y4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    aside4.px   <= px3;
    aside4.zero <= zero3;
    aside4.full <= full3;
    y4          <= y3;
    for (int i = 0; i < 3; i++) begin
      aside4.pmo[i] <= div_one(XW'(cpo3[i]) + ONE_HALF);
      aside4.pmb[i] <= div_one(XW'(cpb3[i]) + ONE_HALF);
    end
  end

  // Blend amount: round(prod / (255 * ONE)). The high bits of the dividend
  // times a scaled reciprocal give an estimate that is low by at most one,
  // and a compare against the remainder adds the missing unit.
  logic                 ve;
  amount_side_t         aside_e;
  logic [YW-1:0]        y_e;
  chan_t                est_e;
  logic [HW+RW-1:0]     est_wide;

  assign est_wide = (HW+RW)'(y4[YW-1:CB]) * (HW+RW)'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else begin
      ve <= v4;
    end
  end

  always_ff @(posedge clk) begin
    aside_e <= aside4;
    y_e     <= y4;
    est_e   <= chan_t'(est_wide >> RS);
  end

  logic            vq;
  amount_side_t    aside_q;
  logic [YW-1:0]   y_q;
  chan_t           est_q;
  logic [YW-1:0]   prod_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= 1'b0;
    end else begin
      vq <= ve;
    end
  end

  always_ff @(posedge clk) begin
    aside_q <= aside_e;
    y_q     <= y_e;
    est_q   <= est_e;
    prod_q  <= YW'(est_e) * YW'(A_DEN);
  end

  logic            va;
  chan_t           amount;
  amount_side_t    aside_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= vq;
    end
  end

  always_ff @(posedge clk) begin
    aside_a <= aside_q;
    amount  <= (y_q >= prod_q + YW'(A_DEN)) ? est_q + chan_t'(1) : est_q;
  end

  // Stage 5: all lerp products. Since ONE is all ones, ONE - a is ~a.
  logic            v5;
  pixel_in_t       px5;
  logic            zero5;
  logic            full5;
  logic [MW-1:0]   pa_o5;
  logic [MW-1:0]   pa_b5;
  rgb_prod_t       pn_o5;
  rgb_prod_t       pn_b5;
  rgb_prod_t       pl_o5;
  rgb_prod_t       pl_b5;
  chan_t           weight;
  rgb_t            back_a;
  rgb_t            fx_a;

  assign weight = ~amount;
  assign back_a = {aside_a.px.back_blue, aside_a.px.back_green, aside_a.px.back_red};
  assign fx_a   = {aside_a.px.fx_blue, aside_a.px.fx_green, aside_a.px.fx_red};

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= va;
    end
  end

  always_ff @(posedge clk) begin
    px5   <= aside_a.px;
    zero5 <= aside_a.zero;
    full5 <= aside_a.full;
    pa_o5 <= MW'(aside_a.px.back_alpha) * MW'(weight);
    pa_b5 <= MW'(aside_a.px.fx_alpha) * MW'(amount);
    for (int i = 0; i < 3; i++) begin
      pn_o5[i] <= MW'(aside_a.pmo[i]) * MW'(weight);
      pn_b5[i] <= MW'(aside_a.pmb[i]) * MW'(amount);
      pl_o5[i] <= MW'(back_a[i]) * MW'(weight);
      pl_b5[i] <= MW'(fx_a[i]) * MW'(amount);
    end
  end

  // Stage 6: sums.
  logic            v6;
  pixel_in_t       px6;
  logic            zero6;
  logic            full6;
  logic [XW-1:0]   asum6;
  rgb_sum_t        nsum6;
  rgb_sum_t        lsum6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    px6   <= px5;
    zero6 <= zero5;
    full6 <= full5;
    asum6 <= XW'(pa_o5) + XW'(pa_b5) + ONE_HALF;
    for (int i = 0; i < 3; i++) begin
      nsum6[i] <= XW'(pn_o5[i]) + XW'(pn_b5[i]);
      lsum6[i] <= XW'(pl_o5[i]) + XW'(pl_b5[i]) + ONE_HALF;
    end
  end

  // Stage 7: new alpha and the straight lerp colors.
  logic            v7;
  pixel_in_t       px7;
  logic            zero7;
  logic            full7;
  chan_t           aout7;
  rgb_t            lerp7;
  rgb_sum_t        nsum7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    px7   <= px6;
    zero7 <= zero6;
    full7 <= full6;
    aout7 <= div_one(asum6);
    nsum7 <= nsum6;
    for (int i = 0; i < 3; i++) begin
      lerp7[i] <= div_one(lsum6[i]);
    end
  end

  // Stage 8: rounded color dividends.
  logic            v8;
  pixel_in_t       px8;
  logic            zero8;
  logic            full8;
  chan_t           aout8;
  rgb_t            lerp8;
  rgb_prod_t       cnum8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    px8   <= px7;
    zero8 <= zero7;
    full8 <= full7;
    aout8 <= aout7;
    lerp8 <= lerp7;
    for (int i = 0; i < 3; i++) begin
      cnum8[i] <= MW'(nsum7[i] + XW'(aout7 >> 1));
    end
  end

  // Stage 9: saturation test and the result for every path but the
  // premultiplied colors, which the divider supplies.
  logic            v9;
  color_side_t     cside9;
  rgb_prod_t       cnum9;
  chan_t           aout9;
  pixel_out_t      prov8;
  logic [2:0]      sat8;

  always_comb begin
    prov8.res_alpha = aout8;
    prov8.res_red   = lerp8[0];
    prov8.res_green = lerp8[1];
    prov8.res_blue  = lerp8[2];
    if (zero8) begin
      prov8.res_red    = px8.back_red;
      prov8.res_green  = px8.back_green;
      prov8.res_blue   = px8.back_blue;
      prov8.res_alpha  = px8.back_alpha;
      prov8.blend_path = PATH_BACK;
    end else if (full8) begin
      prov8.res_red    = px8.fx_red;
      prov8.res_green  = px8.fx_green;
      prov8.res_blue   = px8.fx_blue;
      prov8.res_alpha  = px8.fx_alpha;
      prov8.blend_path = PATH_FX;
    end else if (aout8 == '0) begin
      prov8.blend_path = PATH_LERP;
    end else begin
      prov8.blend_path = PATH_PREMUL;
    end
    for (int i = 0; i < 3; i++) begin
      sat8[i] = (cnum8[i] >= {aout8, CB'(0)});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else begin
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    cside9.prov <= prov8;
    cside9.sat  <= sat8;
    cnum9       <= cnum8;
    aout9       <= aout8;
  end

  // Un-premultiply: color = round(num / new alpha), quotient saturated above.
  logic            vc;
  rgb_t            quot_c;
  color_side_t     cside_c;

  mpb_divider #(
    .LANES  (3),
    .NUM_W  (MW),
    .DEN_W  (CB),
    .Q_BITS (CB),
    .SIDE_W ($bits(color_side_t))
  ) u_color_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v9),
    .in_num    (cnum9),
    .in_den    (aout9),
    .in_side   (cside9),
    .out_valid (vc),
    .out_quot  (quot_c),
    .out_side  (cside_c)
  );

  // Output register.
  pixel_out_t      final_px;
  rgb_t            color_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      color_c[i] = cside_c.sat[i] ? CH_ONE : quot_c[i];
    end
    final_px = cside_c.prov;
    if (cside_c.prov.blend_path == PATH_PREMUL) begin
      final_px.res_red   = color_c[0];
      final_px.res_green = color_c[1];
      final_px.res_blue  = color_c[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vc;
    end
  end

  always_ff @(posedge clk) begin
    result <= final_px;
  end

  // Every accepted pixel leaves after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("pixel did not leave after the pipeline latency");

  // The straight lerp is taken only when the new alpha is zero.
  a_lerp_alpha: assert property (@(posedge clk) disable iff (rst)
    done && result.blend_path == PATH_LERP |-> result.res_alpha == '0)
    else $error("plain lerp path with nonzero alpha");

  // The premultiplied path never divides by a zero alpha.
  a_premul_alpha: assert property (@(posedge clk) disable iff (rst)
    done && result.blend_path == PATH_PREMUL |-> result.res_alpha != '0)
    else $error("premultiplied path with zero alpha");

  // A kept backdrop matches the backdrop of the pixel that produced it.
  a_back_kept: assert property (@(posedge clk) disable iff (rst)
    done && result.blend_path == PATH_BACK |->
      result.res_red == $past(pixel.back_red, LATENCY) &&
      result.res_alpha == $past(pixel.back_alpha, LATENCY))
    else $error("backdrop path changed the backdrop");

endmodule
